### src/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants shared by the length-prefix deframer modules.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int          HDR_CNT_WIDTH   = 3;
    localparam logic [2:0]  HDR_BYTES_SHORT = 3'd2;
    localparam logic [2:0]  HDR_BYTES_LONG  = 3'd4;
    localparam int          FRAME_LEN_WIDTH = 32;

    typedef struct packed {
        logic                       valid;
        logic [7:0]                 payload_byte;
        logic                       frame_first;
        logic                       frame_last;
        logic                       empty_frame;
        logic [FRAME_LEN_WIDTH-1:0] frame_length;
    } result_t;

endpackage

### src/length_prefix_deframer.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer
// Splits a byte stream into length-prefixed frames (big-endian 2/4-byte header).
// ----------------------------------------------------------------------------
// Path: the input reg holds the accepted byte, then the result reg holds its result.
// Throughput: one byte per cycle while the result side does not stall; header bytes give no result.
// The result register can be refilled in the cycle it is taken downstream.
// Reset: asynchronous, clears the frame state, config register and valid flags.
module length_prefix_deframer #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,     // header_four_bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [7:0] payload_byte, [39:8] frame_length
    output logic [1:0]  m_axis_tuser,    // [0] frame_first, [1] empty_frame
    output logic        m_axis_tlast     // frame_last
);

    logic              header_four_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    lpd_pkg::result_t  out_reg;
    lpd_pkg::result_t  res;
    logic              advance;
    logic              step;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_four_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            header_four_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    lpd_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .header_four_bytes (header_four_reg),
        .step              (step),
        .data_byte         (in_byte_reg),
        .res               (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.frame_length, out_reg.payload_byte};
    assign m_axis_tuser  = {out_reg.empty_frame, out_reg.frame_first};
    assign m_axis_tlast  = out_reg.frame_last;

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
        (m_axis_tuser[0] && m_axis_tlast && m_axis_tdata == 40'd0))
        else $error("empty frame result malformed");

    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[39:8] != 32'd0))
        else $error("payload result with zero frame length");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost a stalled byte");

endmodule

### src/lpd_parser.sv
// ----------------------------------------------------------------------------
// lpd_parser
// Header accumulation, payload counting and result formation for one byte.
// ----------------------------------------------------------------------------
module lpd_parser #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              header_four_bytes,
    input  logic              step,
    input  logic [7:0]        data_byte,
    output lpd_pkg::result_t  res
);

    // clamp the kept length bits to 16..32
    localparam int ACC_WIDTH = (LENGTH_WIDTH < 16) ? 16 :
                               (LENGTH_WIDTH > 32) ? 32 : LENGTH_WIDTH;

    localparam logic [ACC_WIDTH-1:0] SHORT_MASK = ACC_WIDTH'(16'hFFFF);
    localparam logic [ACC_WIDTH-1:0] ONE        = ACC_WIDTH'(1);

    logic                    in_payload_reg, in_payload_next;
    logic [1:0]              header_count_reg, header_count_next;
    logic [ACC_WIDTH-1:0]    length_accum_reg, length_accum_next;
    logic [ACC_WIDTH-1:0]    remaining_reg, remaining_next;

    logic [ACC_WIDTH-1:0]                accum_shift;
    logic [ACC_WIDTH-1:0]                new_length;
    logic [lpd_pkg::HDR_CNT_WIDTH-1:0]   count_inc;
    logic [lpd_pkg::HDR_CNT_WIDTH-1:0]   need;
    logic                                header_done;

    assign accum_shift = {length_accum_reg[ACC_WIDTH-9:0], data_byte};
    assign new_length  = accum_shift & (header_four_bytes ? '1 : SHORT_MASK);
    assign count_inc   = {1'b0, header_count_reg} + 3'd1;
    assign need        = header_four_bytes ? lpd_pkg::HDR_BYTES_LONG
                                           : lpd_pkg::HDR_BYTES_SHORT;
    assign header_done = (count_inc >= need);

    always_comb
    begin
        in_payload_next   = in_payload_reg;
        header_count_next = header_count_reg;
        length_accum_next = length_accum_reg;
        remaining_next    = remaining_reg;
        res               = '0;
        if (!in_payload_reg)
        begin
            if (!header_done)
            begin
                length_accum_next = accum_shift;
                header_count_next = count_inc[1:0];
            end
            else
            begin
                header_count_next = 2'd0;
                length_accum_next = new_length;
                if (new_length == '0)
                begin
                    res.valid       = 1'b1;
                    res.frame_first = 1'b1;
                    res.frame_last  = 1'b1;
                    res.empty_frame = 1'b1;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    remaining_next  = new_length;
                end
            end
        end
        else
        begin
            res.valid        = 1'b1;
            res.payload_byte = data_byte;
            res.frame_first  = (remaining_reg == length_accum_reg);
            res.frame_last   = (remaining_reg == ONE);
            res.frame_length = lpd_pkg::FRAME_LEN_WIDTH'(length_accum_reg);
            remaining_next   = remaining_reg - ONE;
            if (remaining_reg == ONE)
            begin
                in_payload_next   = 1'b0;
                length_accum_next = '0;
                header_count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg   <= 1'b0;
            header_count_reg <= 2'd0;
            length_accum_reg <= '0;
            remaining_reg    <= '0;
        end
        else if (step)
        begin
            in_payload_reg   <= in_payload_next;
            header_count_reg <= header_count_next;
            length_accum_reg <= length_accum_next;
            remaining_reg    <= remaining_next;
        end
    end

endmodule

### verif/tb_length_prefix_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefix_deframer
// Self-checking bench for the length-prefix deframer. A byte-level
// scoreboard predicts every payload beat and empty-frame beat from the
// accepted input stream and the header-size setting. Stimulus starts with
// a short directed pass: empty frames, a one-byte frame, extreme byte
// values, and a header-size switch in the middle of a header. It then runs
// phases of random well-formed frames with two- or four-byte headers.
// Phases may end inside a header or a payload, so the header size also
// changes while a frame is open. Sender gaps and receiver stalls vary from
// phase to phase, and every fifth phase holds the receiver off long enough to
// back-pressure the input. A last frame announces the largest length.
// ----------------------------------------------------------------------------
module tb_length_prefix_deframer;

    localparam int          ITEMS           = 1400;
    localparam int          RESET_CYCLES    = 6;
    localparam int          DRAIN_CYCLES    = 4;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          LIMIT_CYCLES    = 400000;
    localparam int unsigned SENDER_IDLE_PCT = 74;
    localparam int unsigned RECV_STALL_PCT  = 74;
    localparam int unsigned BOTH_IDLE_PCT   = 14;
    localparam int          PHASE_BYTES     = 90;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH,
        IDLE_HOLD
    } idle_mode_e;

    typedef struct packed {
        logic [7:0]                          payload;
        logic                                is_first;
        logic                                is_last;
        logic                                is_empty;
        logic [lpd_pkg::FRAME_LEN_WIDTH-1:0] frame_len;
    } frame_beat_t;

    class deframe_scoreboard;
        bit                                  hdr_four;
        bit                                  in_payload;
        logic [1:0]                          hdr_count;
        logic [lpd_pkg::FRAME_LEN_WIDTH-1:0] len_acc;
        logic [lpd_pkg::FRAME_LEN_WIDTH-1:0] remaining;
        frame_beat_t                         expected_beats[$];
        int unsigned                         bytes_in;
        int unsigned                         beats_checked;
        int unsigned                         empties;
        int unsigned                         frames_closed;
        int unsigned                         errors;

        function new();
            hdr_four      = 1'b0;
            in_payload    = 1'b0;
            hdr_count     = '0;
            len_acc       = '0;
            remaining     = '0;
            bytes_in      = 0;
            beats_checked = 0;
            empties       = 0;
            frames_closed = 0;
            errors        = 0;
        endfunction

        function void set_header_four(bit four);
            hdr_four = four;
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction

        function void accept_byte(logic [7:0] b);
            logic [2:0]  need;
            logic [2:0]  cnt;
            frame_beat_t beat;
            bytes_in++;
            if (!in_payload)
            begin
                need    = hdr_four ? lpd_pkg::HDR_BYTES_LONG : lpd_pkg::HDR_BYTES_SHORT;
                cnt     = {1'b0, hdr_count} + 3'd1;
                len_acc = {len_acc[lpd_pkg::FRAME_LEN_WIDTH-9:0], b};
                if (cnt < need)
                begin
                    hdr_count = cnt[1:0];
                end
                else
                begin
                    hdr_count = '0;
                    if (need == lpd_pkg::HDR_BYTES_SHORT)
                        len_acc[lpd_pkg::FRAME_LEN_WIDTH-1:16] = '0;
                    if (len_acc == '0)
                    begin
                        beat.payload   = 8'h00;
                        beat.is_first  = 1'b1;
                        beat.is_last   = 1'b1;
                        beat.is_empty  = 1'b1;
                        beat.frame_len = '0;
                        expected_beats.push_back(beat);
                    end
                    else
                    begin
                        in_payload = 1'b1;
                        remaining  = len_acc;
                    end
                end
            end
            else
            begin
                beat.payload   = b;
                beat.is_first  = (remaining == len_acc);
                beat.is_last   = (remaining == 1);
                beat.is_empty  = 1'b0;
                beat.frame_len = len_acc;
                expected_beats.push_back(beat);
                remaining = remaining - 1;
                if (remaining == '0)
                begin
                    in_payload = 1'b0;
                    len_acc    = '0;
                    hdr_count  = '0;
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_beat(logic [7:0] payload, logic is_first, logic is_last,
                                 logic is_empty,
                                 logic [lpd_pkg::FRAME_LEN_WIDTH-1:0] frame_len);
            frame_beat_t exp_beat;
            if (expected_beats.size() == 0)
            begin
                $error("result with nothing expected: payload_byte %0h frame_length %0h",
                       payload, frame_len);
                errors++;
                return;
            end
            exp_beat = expected_beats.pop_front();
            beats_checked++;
            if (exp_beat.is_empty)
                empties++;
            if (exp_beat.is_last)
                frames_closed++;
            compare_field("payload_byte", exp_beat.payload, payload);
            compare_field("frame_first", exp_beat.is_first, is_first);
            compare_field("frame_last", exp_beat.is_last, is_last);
            compare_field("empty_frame", exp_beat.is_empty, is_empty);
            compare_field("frame_length", exp_beat.frame_len, frame_len);
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_wr_data   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;    // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;              // [7:0] payload_byte, [39:8] frame_length
    logic [1:0]  m_axis_tuser;              // [0] frame_first, [1] empty_frame
    logic        m_axis_tlast;

    deframe_scoreboard sb = new();
    logic [7:0]        byte_q[$];
    int unsigned       queued_bytes = 0;
    idle_mode_e        idle_mode    = IDLE_NONE;
    int unsigned       phase_id     = 0;
    int unsigned       seen_phase   = 0;
    int unsigned       hold_left    = 0;
    int unsigned       cycle_count  = 0;

    length_prefix_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_length_prefix_deframer: errors");
            $finish;
        end
    end

    // request source
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.accept_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >=
                    ((idle_mode == IDLE_SENDER) ? SENDER_IDLE_PCT :
                     (idle_mode == IDLE_BOTH)   ? BOTH_IDLE_PCT : 0))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= byte_q.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink: hold off for a long stretch at the start of a hold phase
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (seen_phase != phase_id && idle_mode == IDLE_HOLD)
            begin
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= $urandom_range(99) >=
                    ((idle_mode == IDLE_RECEIVER) ? RECV_STALL_PCT :
                     (idle_mode == IDLE_BOTH)     ? BOTH_IDLE_PCT : 0);
            end
            seen_phase <= phase_id;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tlast,
                          m_axis_tuser[1], m_axis_tdata[39:8]);
    end

    function automatic void push_byte(logic [7:0] b);
        byte_q.push_back(b);
        queued_bytes++;
    endfunction

    function automatic void queue_header(bit four, logic [31:0] len);
        if (four)
        begin
            push_byte(len[31:24]);
            push_byte(len[23:16]);
        end
        push_byte(len[15:8]);
        push_byte(len[7:0]);
    endfunction

    function automatic void queue_payload(int unsigned count);
        repeat (count)
            push_byte(8'($urandom_range(255)));
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 70)
            return $urandom_range(8, 1);
        if (r < 95)
            return $urandom_range(40, 9);
        return $urandom_range(300, 41);
    endfunction

    task automatic wait_idle();
        while (byte_q.size() != 0 || s_axis_tvalid || sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // write the header size while idle, then close whatever frame is open
    task automatic start_phase(idle_mode_e mode, bit four);
        int unsigned need;
        int unsigned n;
        logic [31:0] acc;
        logic [7:0]  b;
        wait_idle();
        idle_mode   <= mode;
        phase_id    <= phase_id + 1;
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= four;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_header_four(four);
        need = four ? lpd_pkg::HDR_BYTES_LONG : lpd_pkg::HDR_BYTES_SHORT;
        if (sb.in_payload)
        begin
            queue_payload(sb.remaining);
        end
        else if (sb.hdr_count != 0)
        begin
            n   = (need > sb.hdr_count) ? need - sb.hdr_count : 1;
            acc = sb.len_acc;
            repeat (n - 1)
            begin
                push_byte(8'h00);
                acc = acc << 8;
            end
            b = 8'($urandom_range(12));
            push_byte(b);
            acc = {acc[23:0], b};
            if (!four)
                acc[31:16] = '0;
            queue_payload(acc);
        end
    endtask

    initial
    begin : main
        int unsigned phase;
        int unsigned phase_start;
        int unsigned len;
        int unsigned tail;
        bit          four;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        start_phase(IDLE_NONE, 1'b0);
        queue_header(1'b0, 32'd0);
        queue_header(1'b0, 32'd1);
        push_byte(8'hFF);
        queue_header(1'b0, 32'd3);
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte(8'hFF);
        start_phase(IDLE_NONE, 1'b1);
        queue_header(1'b1, 32'd0);
        queue_header(1'b1, 32'd2);
        push_byte(8'h7F);
        push_byte(8'h01);
        // open a long header, then drop to the short one
        push_byte(8'hAB);
        push_byte(8'hCD);
        push_byte(8'h00);
        start_phase(IDLE_NONE, 1'b0);

        phase = 0;
        while (queued_bytes < ITEMS)
        begin
            four = 1'($urandom_range(1));
            start_phase(idle_mode_e'(phase % 5), four);
            phase_start = queued_bytes;
            while (queued_bytes - phase_start < PHASE_BYTES)
            begin
                len = pick_length();
                queue_header(four, len);
                queue_payload(len);
            end
            tail = $urandom_range(9);
            if (tail >= 3 && tail < 6)
            begin
                repeat ($urandom_range(four ? 3 : 1, 1))
                    push_byte(8'h00);
            end
            else if (tail >= 6)
            begin
                len = $urandom_range(30, 2);
                queue_header(four, len);
                queue_payload($urandom_range(len - 1, 1));
            end
            phase++;
        end

        start_phase(IDLE_NONE, 1'b1);
        queue_header(1'b1, 32'hFFFF_FFFF);
        queue_payload(6);
        wait_idle();

        $display("%0d bytes sent over %0d random phases, both header sizes", sb.bytes_in, phase);
        $display("%0d results checked, %0d frames closed, %0d empty frames",
                 sb.beats_checked, sb.frames_closed, sb.empties);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_length_prefix_deframer: clean");
        else
            $display("tb_length_prefix_deframer: errors");
        $finish;
    end

endmodule
